// ===== hw/rtl/ntu_pkg.sv =====
// ntu_pkg: type codes, register indexes and conversion helpers for the
// numeric type upconverter. No dependencies.
package ntu_pkg;

  localparam int unsigned TypeW  = 4;
  localparam int unsigned ElemW  = 64;
  localparam int unsigned PaddrW = 3;

  // element type codes
  localparam logic [TypeW-1:0] TyBin  = 4'd0;
  localparam logic [TypeW-1:0] TyI8   = 4'd1;
  localparam logic [TypeW-1:0] TyI32  = 4'd2;
  localparam logic [TypeW-1:0] TyI16  = 4'd3;
  localparam logic [TypeW-1:0] TyF32  = 4'd4;
  localparam logic [TypeW-1:0] TyF64  = 4'd5;
  localparam logic [TypeW-1:0] TyText = 4'd6;
  localparam logic [TypeW-1:0] TyC64  = 4'd7;
  localparam logic [TypeW-1:0] TyI64  = 4'd8;
  localparam logic [TypeW-1:0] TyMax  = 4'd8;

  // register byte addresses
  localparam logic [PaddrW-1:0] RegSrc = 3'd0;
  localparam logic [PaddrW-1:0] RegDst = 3'd4;

  // size mask by type code
  function automatic logic [63:0] size_mask(input logic [TypeW-1:0] t);
    logic [63:0] m;
    unique case (t)
      TyI32, TyF32: m = 64'h0000_0000_FFFF_FFFF;
      TyI16:        m = 64'h0000_0000_0000_FFFF;
      TyF64, TyC64, TyI64: m = '1;
      default:      m = 64'h0000_0000_0000_00FF;
    endcase
    return m;
  endfunction

  // integer rank, 0 for non-integer types
  function automatic logic [2:0] int_rank(input logic [TypeW-1:0] t);
    logic [2:0] r;
    unique case (t)
      TyI8:    r = 3'd1;
      TyI16:   r = 3'd2;
      TyI32:   r = 3'd3;
      TyI64:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ntu_stream_if.sv =====
// ntu_stream_if: valid/ready channel carrying one item of a given payload.
// Payload type is given by the payload_t parameter.
interface ntu_stream_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ntu_i2f.sv =====
// ntu_i2f: front half of integer to float conversion, combinational.
// Produces sign, magnitude and leading one index; uses ntu_pkg.
module ntu_i2f
  import ntu_pkg::*;
(
  input  logic [63:0] v_i,
  output logic        sign_o,
  output logic [63:0] mag_o,
  output logic [5:0]  msb_o,
  output logic        zero_o
);
  // magnitude of the two's complement value
  assign sign_o = v_i[63];
  assign mag_o  = v_i[63] ? (~v_i + 64'd1) : v_i;
  assign zero_o = (mag_o == '0);

  // leading one search
  always_comb begin
    msb_o = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag_o[i]) msb_o = 6'(i);
    end
  end
endmodule

// ===== hw/rtl/numeric_type_upconverter_core.sv =====
// numeric_type_upconverter_core: top level of the numeric type upconverter.
// Uses ntu_pkg, ntu_stream_if and ntu_i2f.
//
// Converts one element per clock, when the output is not stalled, from the
// configured source type to the configured target type. An item passes an
// input register, a normalise stage register and round/pack logic into the
// output register; throughput is one item per cycle when the output is not
// stalled. A stall on the output holds all stages together. Write
// source_type and target_type over APB only while no item is in flight.
module numeric_type_upconverter_core
  import ntu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ntu_stream_if.sink        in_if,
  ntu_stream_if.source      out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [TypeW-1:0] src_q, dst_q;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= TyI8;
      dst_q <= TyI8;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegSrc) src_q <= pwdata[TypeW-1:0];
      if (paddr == RegDst) dst_q <= pwdata[TypeW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == RegSrc) prdata = {28'd0, src_q};
    if (paddr == RegDst) prdata = {28'd0, dst_q};
  end

  // pipeline advance: all stages move together
  logic v1_q, v2_q, v3_q;
  logic adv;
  assign adv = !v3_q || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: input register
  logic [63:0] x1_q;
  logic        l1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv && in_if.valid) begin
      x1_q <= in_if.data.element_bits;
      l1_q <= in_if.data.last_element;
    end
  end

  // stage 1 decode: sign extension and type pair classification
  logic [63:0] sx;
  logic        is_int, valid_codes;
  always_comb begin
    unique case (src_q)
      TyI8:    sx = {{56{x1_q[7]}}, x1_q[7:0]};
      TyI16:   sx = {{48{x1_q[15]}}, x1_q[15:0]};
      TyI32:   sx = {{32{x1_q[31]}}, x1_q[31:0]};
      default: sx = x1_q;
    endcase
  end
  assign is_int      = int_rank(src_q) != 3'd0;
  assign valid_codes = (src_q <= TyMax) && (dst_q <= TyMax);

  logic        i_sign, i_zero;
  logic [63:0] i_mag;
  logic [5:0]  i_msb;
  ntu_i2f u_i2f (
    .v_i(sx), .sign_o(i_sign), .mag_o(i_mag), .msb_o(i_msb), .zero_o(i_zero)
  );

  // float32 source fields and subnormal leading one
  logic [4:0] f_q;
  always_comb begin
    f_q = '0;
    for (int i = 0; i < 23; i++) begin
      if (x1_q[i]) f_q = 5'(i);
    end
  end

  // stage 2: normalised magnitude
  logic        v2_ok, l2_q, s2_q, z2_q;
  logic [63:0] n2_q, x2_q, sx2_q;
  logic [5:0]  p2_q;
  logic [4:0]  q2_q;
  logic        op_pass_q, op_ext_q, op_f32_q, op_f64_q, op_c32_q, op_ff_q;
  logic [TypeW-1:0] s2t_q, d2t_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      l2_q  <= l1_q;
      s2_q  <= i_sign;
      z2_q  <= i_zero;
      n2_q  <= i_mag << (6'd63 - i_msb);
      p2_q  <= i_msb;
      x2_q  <= x1_q;
      sx2_q <= sx;
      q2_q  <= f_q;
      s2t_q <= src_q;
      d2t_q <= dst_q;
      op_pass_q <= valid_codes && src_q == dst_q;
      op_ext_q  <= valid_codes && src_q != dst_q && is_int &&
                   int_rank(dst_q) != 3'd0 && int_rank(src_q) < int_rank(dst_q);
      op_f32_q  <= valid_codes && src_q != dst_q && is_int &&
                   (dst_q == TyF32 || dst_q == TyC64);
      op_c32_q  <= valid_codes && dst_q == TyC64 && src_q == TyF32;
      op_f64_q  <= valid_codes && src_q != dst_q && is_int && dst_q == TyF64;
      op_ff_q   <= valid_codes && dst_q == TyF64 && src_q == TyF32;
    end
  end
  assign v2_ok = op_pass_q | op_ext_q | op_f32_q | op_c32_q | op_f64_q | op_ff_q;

  // stage 2 round and pack
  logic [24:0] k32;
  logic [53:0] k64;
  logic        g32, st32, g64, st64;
  logic [7:0]  e32;
  logic [10:0] e64;
  logic [31:0] r32;
  logic [63:0] r64, rff, res;
  logic [7:0]  fe;
  logic [22:0] ff;
  always_comb begin
    // float32: 24 kept bits from n2_q[63:40]
    g32  = n2_q[39];
    st32 = |n2_q[38:0];
    k32  = {1'b0, n2_q[63:40]} + 25'(g32 && (st32 || n2_q[40]));
    e32  = 8'(p2_q) + 8'd127 + 8'(k32[24]);
    r32  = z2_q ? 32'd0 :
           {s2_q, e32, (k32[24] ? k32[23:1] : k32[22:0])};
    // float64: 53 kept bits from n2_q[63:11]
    g64  = n2_q[10];
    st64 = |n2_q[9:0];
    k64  = {1'b0, n2_q[63:11]} + 54'(g64 && (st64 || n2_q[11]));
    e64  = 11'(p2_q) + 11'd1023 + 11'(k64[53]);
    r64  = z2_q ? 64'd0 :
           {s2_q, e64, (k64[53] ? k64[52:1] : k64[51:0])};
    // float32 to float64
    fe = x2_q[30:23];
    ff = x2_q[22:0];
    if (fe == 8'hFF) begin
      rff = {x2_q[31], 11'h7FF, (ff == '0) ? 52'd0 : {1'b1, ff[21:0], 29'd0}};
      if (ff != '0) rff[51:29] = rff[51:29] | ff;
    end else if (fe == 8'd0) begin
      if (ff == '0) rff = {x2_q[31], 63'd0};
      else rff = {x2_q[31], 11'(q2_q) + 11'd874,
                  52'(({29'd0, ff} << (6'd52 - 6'(q2_q))))};
    end else begin
      rff = {x2_q[31], 11'(fe) + 11'd896, ff, 29'd0};
    end
    res = '0;
    if (op_pass_q)     res = x2_q & size_mask(s2t_q);
    else if (op_ext_q) res = sx2_q & size_mask(d2t_q);
    else if (op_f32_q) res = {32'd0, r32};
    else if (op_c32_q) res = {32'd0, x2_q[31:0]};
    else if (op_f64_q) res = r64;
    else if (op_ff_q)  res = rff;
  end

  // stage 3: output register
  logic [63:0] r3_q;
  logic        l3_q, u3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      r3_q <= res;
      l3_q <= l2_q;
      u3_q <= !v2_ok;
    end
  end
  assign out_if.valid = v3_q;
  assign out_if.data.converted_bits = r3_q;
  assign out_if.data.last_out       = l3_q;
  assign out_if.data.unsupported    = u3_q;
endmodule

// ===== hw/rtl/ntu_checker.sv =====
// ntu_checker: port-level assertions for numeric_type_upconverter_core.
// Bound to the top level; uses ntu_pkg.
module ntu_checker
  import ntu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bits,
  input logic        out_unsup,
  input logic        pready
);
  // unsupported results carry zero bits
  a_unsup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_unsup |-> out_bits == '0) else $error("unsupported nonzero");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_bits))
    else $error("result dropped");
  // input stalls only behind a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready) else $error("needless stall");
  a_pready: assert property (@(posedge clk_i) pready) else $error("pready low");
endmodule

bind numeric_type_upconverter_core ntu_checker u_ntu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_bits(out_if.data.converted_bits), .out_unsup(out_if.data.unsupported),
  .pready(pready)
);
